// ----- src/tccs_pkg.sv -----
// Shared types, codes and default sizes of the text console cursor and scrollback engine.
// No dependencies; every other file of the block imports this package.
package tccs_pkg;

    // Default geometry, handed to the top level as parameter defaults.
    localparam int LINE_WIDTH_DEF   = 80;
    localparam int LINE_COUNT_DEF   = 25;
    localparam int TAB_WIDTH_DEF    = 8;
    localparam int SCREENS_KEPT_DEF = 10;

    // Fixed field widths of the two channels.
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 11;
    localparam int IDX_W  = 15;
    localparam int SPOS_W = 16;
    localparam int VIEW_W = 15;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PRINT       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SCROLL_UP   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SCROLL_DOWN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SET_CURSOR  = 2'd3;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_BELL      = 8'd7;

    // Character classes reported by the datapath.
    typedef logic [2:0] ch_class_t;
    localparam ch_class_t CK_OTHER     = 3'd0;
    localparam ch_class_t CK_NEWLINE   = 3'd1;
    localparam ch_class_t CK_BACKSPACE = 3'd2;
    localparam ch_class_t CK_TAB       = 3'd3;
    localparam ch_class_t CK_BELL      = 3'd4;

    // Datapath operations issued by the controller.
    typedef logic [3:0] op_t;
    localparam op_t OP_NONE        = 4'd0;
    localparam op_t OP_SNAP        = 4'd1;
    localparam op_t OP_MOD_BUFFER  = 4'd2;
    localparam op_t OP_MOD_SCREEN  = 4'd3;
    localparam op_t OP_MOD_COL     = 4'd4;
    localparam op_t OP_NEWLINE     = 4'd5;
    localparam op_t OP_TAB         = 4'd6;
    localparam op_t OP_BACKSPACE   = 4'd7;
    localparam op_t OP_CHAR        = 4'd8;
    localparam op_t OP_FIX_STORE   = 4'd9;
    localparam op_t OP_FIX_SCREEN  = 4'd10;
    localparam op_t OP_SCROLL_UP   = 4'd11;
    localparam op_t OP_SCROLL_DOWN = 4'd12;
    localparam op_t OP_SET_CURSOR  = 4'd13;
    localparam op_t OP_LOAD_OUT    = 4'd14;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  screen_position;
    } in_t;

    typedef struct packed {
        logic                     write_valid;
        logic [IDX_W-1:0]         write_index;
        logic [CHAR_W-1:0]        write_char;
        logic                     shift_rows;
        logic signed [SPOS_W-1:0] cursor_screen_pos;
        logic [VIEW_W-1:0]        view_first_cell;
        logic                     cursor_visible;
    } out_t;

    typedef struct packed {
        logic capture;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        ch_class_t        ch_class;
        logic             snap_ok;
        logic             row_busy;
        logic             col_busy;
    } stat_t;

endpackage

// ----- src/tccs_rowmod.sv -----
// Remainder unit: x modulo a constant divisor by reciprocal multiplication.
// Depends on tccs_pkg for the default divisor.
module tccs_rowmod #(
    parameter int DIVISOR = tccs_pkg::LINE_WIDTH_DEF,
    parameter int XW      = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [XW-1:0] x,
    output logic          busy,
    output logic [XW-1:0] rem
);
    import tccs_pkg::*;

    // With a shift of XW plus the ceiling of log2 of the divisor and the reciprocal
    // rounded up, the quotient is exact for every XW-bit operand.
    localparam int DLOG = $clog2(DIVISOR);
    localparam int SH   = XW + DLOG;
    localparam int MW   = XW + 1;
    localparam int DVW  = DLOG + 1;

    localparam longint MULT = ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

    localparam logic [MW-1:0]  MULT_V = MW'(MULT);
    localparam logic [DVW-1:0] DIV_V  = DVW'(DIVISOR);

    logic [XW-1:0]     x_reg, x_next;
    logic [XW-1:0]     q_reg, q_next;
    logic [XW-1:0]     rem_reg, rem_next;
    logic              busy_reg, busy_next;
    logic              step_reg, step_next;
    logic [XW+MW-1:0]  prod;
    logic [XW+DVW-1:0] qd;

    assign prod = x_reg * MULT_V;
    assign qd   = q_reg * DIV_V;

    always_comb begin
        x_next    = x_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        step_next = step_reg;
        if (start) begin
            x_next    = x;
            busy_next = 1'b1;
            step_next = 1'b0;
        end else if (busy_reg) begin
            if (!step_reg) begin
                q_next    = XW'(prod >> SH);
                step_next = 1'b1;
            end else begin
                // The quotient times the divisor never exceeds x, so it fits XW bits.
                rem_next  = x_reg - XW'(qd);
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/tccs_datapath.sv -----
// Datapath of the console engine: cursor, view and write registers, the two remainder
// units and the result register. Depends on tccs_pkg and tccs_rowmod.
module tccs_datapath #(
    parameter int LINE_WIDTH   = tccs_pkg::LINE_WIDTH_DEF,
    parameter int LINE_COUNT   = tccs_pkg::LINE_COUNT_DEF,
    parameter int TAB_WIDTH    = tccs_pkg::TAB_WIDTH_DEF,
    parameter int SCREENS_KEPT = tccs_pkg::SCREENS_KEPT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  tccs_pkg::in_t  s_data,
    input  tccs_pkg::cmd_t cmd,
    output tccs_pkg::stat_t stat,
    output tccs_pkg::out_t m_data
);
    import tccs_pkg::*;

    localparam int SCREEN_CELLS = LINE_WIDTH * LINE_COUNT;
    localparam int STORE_CELLS  = SCREEN_CELLS * SCREENS_KEPT;
    localparam int CW_RAW       = $clog2(2 * (STORE_CELLS + SCREEN_CELLS));
    localparam int CW           = (CW_RAW > POS_W + 1) ? CW_RAW : POS_W + 1;
    localparam int SW           = CW + 1;
    localparam int CLW          = $clog2(LINE_WIDTH);

    localparam logic [CW-1:0] LW_U          = CW'(LINE_WIDTH);
    localparam logic [CW-1:0] TW_U          = CW'(TAB_WIDTH);
    localparam logic [CW-1:0] STORE_U       = CW'(STORE_CELLS);
    localparam logic [CW-1:0] STORE_LAST_U  = CW'(STORE_CELLS - 1);
    localparam logic [CW-1:0] STORE_PLUS_LW = CW'(STORE_CELLS + LINE_WIDTH);
    localparam logic [CW-1:0] SCREEN_LAST_U = CW'(SCREEN_CELLS - 1);

    localparam logic signed [SW-1:0] LW_S      = SW'(LINE_WIDTH);
    localparam logic signed [SW-1:0] LW_LAST_S = SW'(LINE_WIDTH - 1);
    localparam logic signed [SW-1:0] SCREEN_S  = SW'(SCREEN_CELLS);
    localparam logic signed [SW-1:0] ONE_S     = SW'(1);

    logic [REQ_W-1:0]  req_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [POS_W-1:0]  pos_reg;

    logic [CW-1:0]        buffer_reg, buffer_next;
    logic signed [SW-1:0] screen_reg, screen_next;
    logic [CW-1:0]        view_reg, view_next;
    logic                 shown_reg, shown_next;
    logic                 wr_reg, wr_next;
    logic                 shift_reg, shift_next;
    logic [CW-1:0]        widx_reg, widx_next;
    out_t                 out_reg, out_next;

    logic                 row_start, col_start, row_busy, col_busy;
    logic [CW-1:0]        row_x, row_rem;
    logic [CLW-1:0]       col_rem;
    logic [CW-1:0]        delta_nl, delta_tab, view_up, pos_ext, pos_sat, set_sum;
    logic signed [SW-1:0] sc_up, sc_dn;
    ch_class_t            ch_class;

    // Remainder of the buffer or screen cursor by the line width, then column by tab width.
    assign row_start = (cmd.op == OP_MOD_BUFFER) || (cmd.op == OP_MOD_SCREEN);
    assign row_x     = (cmd.op == OP_MOD_SCREEN) ? screen_reg[CW-1:0] : buffer_reg;
    assign col_start = (cmd.op == OP_MOD_COL);

    tccs_rowmod #(
        .DIVISOR (LINE_WIDTH),
        .XW      (CW)
    ) u_rowmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (row_start),
        .x       (row_x),
        .busy    (row_busy),
        .rem     (row_rem)
    );

    tccs_rowmod #(
        .DIVISOR (TAB_WIDTH),
        .XW      (CLW)
    ) u_colmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (col_start),
        .x       (row_rem[CLW-1:0]),
        .busy    (col_busy),
        .rem     (col_rem)
    );

    assign delta_nl  = LW_U - row_rem;
    assign delta_tab = TW_U - CW'(col_rem);
    assign view_up   = (view_reg < LW_U) ? '0 : view_reg - LW_U;
    assign sc_up     = screen_reg + LW_S;
    assign sc_dn     = screen_reg - LW_S;
    assign pos_ext   = CW'(pos_reg);
    assign pos_sat   = (pos_ext > SCREEN_LAST_U) ? SCREEN_LAST_U : pos_ext;
    assign set_sum   = view_reg + pos_sat;

    always_comb begin
        unique case (ch_reg)
            CH_NEWLINE:   ch_class = CK_NEWLINE;
            CH_BACKSPACE: ch_class = CK_BACKSPACE;
            CH_TAB:       ch_class = CK_TAB;
            CH_BELL:      ch_class = CK_BELL;
            default:      ch_class = CK_OTHER;
        endcase
    end

    assign stat.req      = req_reg;
    assign stat.ch_class = ch_class;
    assign stat.snap_ok  = !screen_reg[SW-1] && (screen_reg < SCREEN_S);
    assign stat.row_busy = row_busy;
    assign stat.col_busy = col_busy;

    always_comb begin
        buffer_next = buffer_reg;
        screen_next = screen_reg;
        view_next   = view_reg;
        shown_next  = shown_reg;
        wr_next     = wr_reg;
        shift_next  = shift_reg;
        widx_next   = widx_reg;
        out_next    = out_reg;
        if (cmd.capture) begin
            wr_next    = 1'b0;
            shift_next = 1'b0;
        end
        unique case (cmd.op) inside
            OP_SNAP: begin
                if (screen_reg[SW-1]) begin
                    screen_next = sc_up;
                    view_next   = view_up;
                end else if (screen_reg >= SCREEN_S) begin
                    screen_next = sc_dn;
                    view_next   = view_reg + LW_U;
                end
            end
            OP_NEWLINE: begin
                buffer_next = buffer_reg + delta_nl;
                screen_next = screen_reg + $signed({1'b0, delta_nl});
            end
            OP_TAB: begin
                buffer_next = buffer_reg + delta_tab;
                screen_next = screen_reg + $signed({1'b0, delta_tab});
            end
            OP_BACKSPACE: begin
                if (buffer_reg != '0) begin
                    buffer_next = buffer_reg - 1'b1;
                    if (screen_reg == '0) begin
                        screen_next = LW_LAST_S;
                        view_next   = view_up;
                    end else begin
                        screen_next = screen_reg - ONE_S;
                    end
                end
            end
            OP_CHAR: begin
                wr_next     = 1'b1;
                widx_next   = buffer_reg;
                buffer_next = buffer_reg + 1'b1;
                screen_next = screen_reg + ONE_S;
            end
            OP_FIX_STORE: begin
                if (buffer_reg >= STORE_U) begin
                    shift_next  = 1'b1;
                    buffer_next = (buffer_reg >= STORE_PLUS_LW) ? STORE_LAST_U
                                                                : buffer_reg - LW_U;
                    view_next   = view_up;
                    widx_next   = widx_reg - LW_U;
                end
            end
            OP_FIX_SCREEN: begin
                if (screen_reg >= SCREEN_S) begin
                    screen_next = sc_dn;
                    view_next   = view_reg + LW_U;
                end
                shown_next = 1'b1;
            end
            OP_SCROLL_UP: begin
                if (view_reg != '0) begin
                    screen_next = sc_up;
                    view_next   = view_up;
                    if (sc_up >= SCREEN_S) begin
                        shown_next = 1'b0;
                    end else if (!sc_up[SW-1]) begin
                        shown_next = 1'b1;
                    end
                end
            end
            OP_SCROLL_DOWN: begin
                if (!screen_reg[SW-1]) begin
                    screen_next = sc_dn;
                    view_next   = view_reg + LW_U;
                    if (sc_dn[SW-1]) begin
                        shown_next = 1'b0;
                    end else if (sc_dn < SCREEN_S) begin
                        shown_next = 1'b1;
                    end
                end
            end
            OP_SET_CURSOR: begin
                screen_next = $signed({1'b0, pos_sat});
                buffer_next = (set_sum >= STORE_U) ? STORE_LAST_U : set_sum;
            end
            OP_LOAD_OUT: begin
                out_next.write_valid       = wr_reg;
                out_next.write_index       = wr_reg ? IDX_W'(widx_reg) : '0;
                out_next.write_char        = wr_reg ? ch_reg : '0;
                out_next.shift_rows        = shift_reg;
                out_next.cursor_screen_pos = SPOS_W'(screen_reg);
                out_next.view_first_cell   = VIEW_W'(view_reg);
                out_next.cursor_visible    = shown_reg;
            end
            OP_NONE, OP_MOD_BUFFER, OP_MOD_SCREEN, OP_MOD_COL: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_reg <= '0;
            screen_reg <= '0;
            view_reg   <= '0;
            shown_reg  <= 1'b1;
        end else begin
            buffer_reg <= buffer_next;
            screen_reg <= screen_next;
            view_reg   <= view_next;
            shown_reg  <= shown_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data.req_type;
            ch_reg  <= s_data.char_code;
            pos_reg <= s_data.screen_position;
        end
        wr_reg    <= wr_next;
        shift_reg <= shift_next;
        widx_reg  <= widx_next;
        out_reg   <= out_next;
    end

    assign m_data = out_reg;

    // The store correction always leaves the buffer cursor inside the store.
    a_store_fixed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIX_STORE) |=> (buffer_reg < STORE_U))
        else $error("buffer cursor beyond the store after correction");

    // A written cell, moved by any row shift, still lies inside the store.
    a_write_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIX_STORE) && wr_reg |=> (widx_reg < STORE_U))
        else $error("write index beyond the store");

    // After a print the screen cursor is never above the view.
    a_print_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIX_SCREEN) |=> !screen_reg[SW-1])
        else $error("screen cursor above the view after a print");

endmodule

// ----- src/tccs_ctrl.sv -----
// Controller of the console engine: sequences the datapath operations of each request
// and owns both handshakes. Depends on tccs_pkg.
module tccs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output tccs_pkg::cmd_t  cmd,
    input  tccs_pkg::stat_t stat
);
    import tccs_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_DECODE     = 3'd1;
    localparam logic [2:0] S_ROW_WAIT   = 3'd2;
    localparam logic [2:0] S_COL_WAIT   = 3'd3;
    localparam logic [2:0] S_FIX_STORE  = 3'd4;
    localparam logic [2:0] S_FIX_SCREEN = 3'd5;
    localparam logic [2:0] S_DONE       = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       load;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = s_valid && s_ready;
        cmd.op      = OP_NONE;
        load        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.req != REQ_PRINT) begin
                    unique case (stat.req)
                        REQ_SCROLL_UP:   cmd.op = OP_SCROLL_UP;
                        REQ_SCROLL_DOWN: cmd.op = OP_SCROLL_DOWN;
                        default:         cmd.op = OP_SET_CURSOR;
                    endcase
                    state_next = S_DONE;
                end else if (!stat.snap_ok) begin
                    // Bring the view back by one row per cycle until the cursor is shown.
                    cmd.op = OP_SNAP;
                end else begin
                    unique case (stat.ch_class)
                        CK_NEWLINE: begin
                            cmd.op     = OP_MOD_BUFFER;
                            state_next = S_ROW_WAIT;
                        end
                        CK_TAB: begin
                            cmd.op     = OP_MOD_SCREEN;
                            state_next = S_ROW_WAIT;
                        end
                        CK_BACKSPACE: begin
                            cmd.op     = OP_BACKSPACE;
                            state_next = S_FIX_STORE;
                        end
                        CK_BELL: begin
                            state_next = S_FIX_STORE;
                        end
                        default: begin
                            cmd.op     = OP_CHAR;
                            state_next = S_FIX_STORE;
                        end
                    endcase
                end
            end
            S_ROW_WAIT: begin
                if (!stat.row_busy) begin
                    if (stat.ch_class == CK_TAB) begin
                        cmd.op     = OP_MOD_COL;
                        state_next = S_COL_WAIT;
                    end else begin
                        cmd.op     = OP_NEWLINE;
                        state_next = S_FIX_STORE;
                    end
                end
            end
            S_COL_WAIT: begin
                if (!stat.col_busy) begin
                    cmd.op     = OP_TAB;
                    state_next = S_FIX_STORE;
                end
            end
            S_FIX_STORE: begin
                cmd.op     = OP_FIX_STORE;
                state_next = S_FIX_SCREEN;
            end
            S_FIX_SCREEN: begin
                cmd.op     = OP_FIX_SCREEN;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = OP_LOAD_OUT;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- src/text_console_cursor_scrollback.sv -----
// Top level of the text console cursor and scrollback engine.
// Depends on tccs_pkg, tccs_ctrl and tccs_datapath (which holds two tccs_rowmod units).
//
// The engine takes one request beat at a time on the s_ channel (print a character, scroll
// the view up or down by one row, or place the cursor on the screen) and returns exactly one
// result beat on the m_ channel for each, carrying the cell write, if any, the row-shift flag
// and the new cursor and view position. Requests are handled one after another. A scroll or
// set-cursor request is decoded and applied at once, and its result is then loaded. A print
// first brings the view back to the cursor row by row, then applies the character, corrects
// the buffer cursor against the store and the screen cursor against the screen, and loads
// the result. A newline first waits for the row remainder unit, which finds the column by a
// reciprocal multiplication followed by a multiply-back and subtract. A tab then runs a
// second, narrower remainder unit for its column within the tab stop. The result sits in an
// output register, so a new request beat is accepted as soon as the previous result is
// loaded, even while that result still waits to be taken; the engine only stalls at the end
// of a request if the earlier result has not yet gone. There is no memory to clear after
// reset, and the first request may follow reset at once.
module text_console_cursor_scrollback #(
    parameter int LINE_WIDTH   = tccs_pkg::LINE_WIDTH_DEF,
    parameter int LINE_COUNT   = tccs_pkg::LINE_COUNT_DEF,
    parameter int TAB_WIDTH    = tccs_pkg::TAB_WIDTH_DEF,
    parameter int SCREENS_KEPT = tccs_pkg::SCREENS_KEPT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tccs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tccs_pkg::out_t m_data
);
    import tccs_pkg::*;

    // The controller issues one datapath operation per cycle and reads back a few status
    // flags: the captured request type, the class of the character, whether the cursor is
    // already on screen and whether either remainder unit is still working.
    cmd_t  cmd;
    stat_t stat;

    tccs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath keeps the buffer cursor, the signed screen cursor, the first cell of the
    // view and the cursor visibility, together with the result register behind m_data.
    tccs_datapath #(
        .LINE_WIDTH   (LINE_WIDTH),
        .LINE_COUNT   (LINE_COUNT),
        .TAB_WIDTH    (TAB_WIDTH),
        .SCREENS_KEPT (SCREENS_KEPT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ----- dv/tccs_result_checker.sv -----
// Result checker for the text console cursor and scrollback engine.
// Depends on tccs_pkg for the beat structs, request codes and control characters.
module tccs_result_checker #(
    parameter int LINE_WIDTH   = tccs_pkg::LINE_WIDTH_DEF,
    parameter int LINE_COUNT   = tccs_pkg::LINE_COUNT_DEF,
    parameter int TAB_WIDTH    = tccs_pkg::TAB_WIDTH_DEF,
    parameter int SCREENS_KEPT = tccs_pkg::SCREENS_KEPT_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  tccs_pkg::in_t  s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  tccs_pkg::out_t m_data,
    output int             mismatches,
    output int             outstanding,
    output int             checked,
    output int             shifted
);
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    localparam int SCREEN_CELLS = LINE_WIDTH * LINE_COUNT;
    localparam int STORE_CELLS  = SCREEN_CELLS * SCREENS_KEPT;

    // Console state as the engine should hold it.
    int   buf_pos;
    int   scr_pos;
    int   view_top;
    logic cur_shown;

    out_t expected_results[$];

    // Moves the view one row towards the top of the store, stopping at its first row.
    function automatic void view_row_up();
        if (view_top < LINE_WIDTH) begin
            view_top = 0;
        end else begin
            view_top -= LINE_WIDTH;
        end
    endfunction

    function automatic out_t apply_request(input in_t rq);
        out_t res;
        int   step;
        int   widx;
        int   pos;
        logic wr;
        logic shift;
        res   = '0;
        step  = 0;
        widx  = 0;
        wr    = 1'b0;
        shift = 1'b0;
        pos   = int'(rq.screen_position);
        case (rq.req_type)
            REQ_PRINT: begin
                // Bring the view back over the cursor before anything is printed.
                while (scr_pos < 0) begin
                    scr_pos += LINE_WIDTH;
                    view_row_up();
                end
                while (scr_pos >= SCREEN_CELLS) begin
                    scr_pos  -= LINE_WIDTH;
                    view_top += LINE_WIDTH;
                end
                case (rq.char_code)
                    CH_NEWLINE: begin
                        step     = LINE_WIDTH - buf_pos % LINE_WIDTH;
                        buf_pos += step;
                        scr_pos += step;
                    end
                    CH_BACKSPACE: begin
                        if (buf_pos != 0) begin
                            buf_pos--;
                            scr_pos--;
                            if (scr_pos < 0) begin
                                scr_pos += LINE_WIDTH;
                                view_row_up();
                            end
                        end
                    end
                    CH_TAB: begin
                        step     = TAB_WIDTH - (scr_pos % LINE_WIDTH) % TAB_WIDTH;
                        buf_pos += step;
                        scr_pos += step;
                    end
                    CH_BELL: begin
                    end
                    default: begin
                        wr   = 1'b1;
                        widx = buf_pos;
                        buf_pos++;
                        scr_pos++;
                    end
                endcase
                if (buf_pos >= STORE_CELLS) begin
                    shift    = 1'b1;
                    buf_pos -= LINE_WIDTH;
                    view_row_up();
                    widx    -= LINE_WIDTH;
                    if (buf_pos >= STORE_CELLS) begin
                        buf_pos = STORE_CELLS - 1;
                    end
                end
                if (scr_pos >= SCREEN_CELLS) begin
                    scr_pos  -= LINE_WIDTH;
                    view_top += LINE_WIDTH;
                end
                cur_shown = 1'b1;
            end
            REQ_SCROLL_UP: begin
                if (view_top != 0) begin
                    scr_pos += LINE_WIDTH;
                    view_row_up();
                    if (scr_pos >= SCREEN_CELLS) begin
                        cur_shown = 1'b0;
                    end else if (scr_pos >= 0) begin
                        cur_shown = 1'b1;
                    end
                end
            end
            REQ_SCROLL_DOWN: begin
                if (scr_pos >= 0) begin
                    scr_pos  -= LINE_WIDTH;
                    view_top += LINE_WIDTH;
                    if (scr_pos < 0) begin
                        cur_shown = 1'b0;
                    end else if (scr_pos < SCREEN_CELLS) begin
                        cur_shown = 1'b1;
                    end
                end
            end
            default: begin
                if (pos >= SCREEN_CELLS) begin
                    pos = SCREEN_CELLS - 1;
                end
                scr_pos = pos;
                buf_pos = pos + view_top;
                if (buf_pos >= STORE_CELLS) begin
                    buf_pos = STORE_CELLS - 1;
                end
            end
        endcase
        res.write_valid       = wr;
        res.write_index       = wr ? widx[IDX_W-1:0] : '0;
        res.write_char        = wr ? rq.char_code : '0;
        res.shift_rows        = shift;
        res.cursor_screen_pos = scr_pos[SPOS_W-1:0];
        res.view_first_cell   = view_top[VIEW_W-1:0];
        res.cursor_visible    = cur_shown;
        return res;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s differs: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            buf_pos   = 0;
            scr_pos   = 0;
            view_top  = 0;
            cur_shown = 1'b1;
            expected_results.delete();
        end else begin
            // Results are taken before requests, as a request's result never leaves at once.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat arrived with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("write_valid", want.write_valid, m_data.write_valid);
                    check_field("write_index", want.write_index, m_data.write_index);
                    check_field("write_char", want.write_char, m_data.write_char);
                    check_field("shift_rows", want.shift_rows, m_data.shift_rows);
                    check_field("cursor_screen_pos", want.cursor_screen_pos,
                                m_data.cursor_screen_pos);
                    check_field("view_first_cell", want.view_first_cell,
                                m_data.view_first_cell);
                    check_field("cursor_visible", want.cursor_visible, m_data.cursor_visible);
                    checked++;
                    if (want.shift_rows) begin
                        shifted++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_request(s_data));
            end
        end
        outstanding <= expected_results.size();
    end

endmodule

// ----- dv/tb_text_console_cursor_scrollback.sv -----
// Testbench top for the text console cursor and scrollback engine.
// Depends on tccs_pkg, the engine itself and tccs_result_checker, which judges every result beat.
module tb_text_console_cursor_scrollback;
    timeunit 1ns;
    timeprecision 1ps;

    import tccs_pkg::*;

    // Minimum number of random request beats after the directed opening.
    localparam int RANDOM_BEATS = 750;
    // At most this many climbs towards the end of the store, so the view stays in range.
    localparam int MAX_CLIMBS = 9;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    int mismatch_total;
    int pending;
    int results_checked;
    int rows_shifted;

    // Request counts for the closing summary, and a switch that turns all idling off
    // for a stretch so that back-to-back beats are exercised as well.
    int n_sent;
    int n_print;
    int n_scroll;
    int n_set;
    bit calm;

    text_console_cursor_scrollback i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tccs_result_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatch_total),
        .outstanding (pending),
        .checked     (results_checked),
        .shifted     (rows_shifted)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Idle length: usually none or a short gap, now and then a long pause.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 96) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(15, 40);
    endfunction

    // A character for a line of text: mostly printable, with the control characters
    // well represented and a share of arbitrary bytes so that every bit toggles.
    function automatic logic [CHAR_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return CHAR_W'($urandom_range(32, 126));
        end else if (roll < 60) begin
            return CH_NEWLINE;
        end else if (roll < 68) begin
            return CH_TAB;
        end else if (roll < 76) begin
            return CH_BACKSPACE;
        end else if (roll < 80) begin
            return CH_BELL;
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Cursor cells lean towards the screen corners, row starts and the saturating range.
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return POS_W'($urandom_range(0, 2047));
        end else if (roll < 60) begin
            return POS_W'($urandom_range(1990, 2047));
        end else if (roll < 80) begin
            return POS_W'($urandom_range(0, 10));
        end
        return POS_W'(LINE_WIDTH_DEF * $urandom_range(0, LINE_COUNT_DEF - 1));
    endfunction

    // Presents one request beat after an optional idle gap and returns once it is taken.
    // Valid is only dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                                input logic [POS_W-1:0] pos);
        in_t beat;
        int  gap;
        beat.req_type        = req;
        beat.char_code       = ch;
        beat.screen_position = pos;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        case (req) inside
            REQ_PRINT: n_print++;
            REQ_SCROLL_UP, REQ_SCROLL_DOWN: n_scroll++;
            default: n_set++;
        endcase
        n_sent++;
    endtask

    // Shorthands that fill the unused fields of a beat with random noise.
    task automatic print_char(input logic [CHAR_W-1:0] ch);
        send_request(REQ_PRINT, ch, POS_W'($urandom_range(0, 2047)));
    endtask

    task automatic scroll_view(input logic [REQ_W-1:0] dir);
        send_request(dir, CHAR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)));
    endtask

    task automatic place_cursor(input logic [POS_W-1:0] pos);
        send_request(REQ_SET_CURSOR, CHAR_W'($urandom_range(0, 255)), pos);
    endtask

    // The result side stalls at random too; a stall starts only on a cycle where ready
    // was raised, so each edge sees a single assignment to m_ready.
    initial begin : result_stalls
        int hold;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) begin
                    hold = idle_cycles();
                end
            end
        end
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #15_000_000;
        $display("text_console_cursor_scrollback: mismatch");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int len;
        int climbs;
        int target;
        climbs   = 0;
        calm     = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening. Character extremes and every control character first.
        print_char(8'h48);
        print_char(8'h00);
        print_char(8'hFF);
        print_char(CH_TAB);
        print_char(CH_BELL);
        print_char(CH_BACKSPACE);
        print_char(CH_NEWLINE);
        // Scrolling up while the view is already at the top of the store changes nothing.
        scroll_view(REQ_SCROLL_UP);
        // Backspace with the buffer cursor at the very first cell is ignored.
        place_cursor(11'd0);
        print_char(CH_BACKSPACE);
        // Scrolling down hides the cursor; once it is above the view a further scroll
        // down is refused, and scrolling back up shows it again.
        scroll_view(REQ_SCROLL_DOWN);
        scroll_view(REQ_SCROLL_DOWN);
        scroll_view(REQ_SCROLL_UP);
        // A cursor cell past the screen saturates to its last cell, and printing there
        // pushes the view on by a row.
        place_cursor(11'd2047);
        print_char(8'h78);
        place_cursor(11'd2000);
        place_cursor(11'd1999);
        // Backspace from the top-left cell moves the view up a row.
        place_cursor(11'd0);
        print_char(CH_BACKSPACE);
        // A view scrolled away from the cursor snaps back before the next character.
        scroll_view(REQ_SCROLL_DOWN);
        scroll_view(REQ_SCROLL_DOWN);
        print_char(8'h79);
        place_cursor(11'd1999);
        print_char(CH_TAB);

        // Random part, built from short well-formed sequences with random content.
        target = n_sent + RANDOM_BEATS;
        while (n_sent < target) begin
            calm = ($urandom_range(0, 9) < 2);
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // A line of text.
                len = $urandom_range(1, 20);
                repeat (len) print_char(pick_char());
            end else if (kind < 60) begin
                if (climbs < MAX_CLIMBS) begin
                    // Climb towards the end of the store: cursor to the bottom of the
                    // screen, then scroll the view past it, one row more now and then.
                    climbs++;
                    place_cursor(11'd1999);
                    len = LINE_COUNT_DEF + $urandom_range(0, 2);
                    repeat (len) scroll_view(REQ_SCROLL_DOWN);
                    print_char(pick_char());
                end else begin
                    // Near the end of the store, newlines and text keep the rows shifting.
                    len = $urandom_range(10, 40);
                    repeat (len) begin
                        if ($urandom_range(0, 3) == 0) begin
                            print_char(CH_NEWLINE);
                        end else begin
                            print_char(pick_char());
                        end
                    end
                end
            end else if (kind < 72) begin
                len = $urandom_range(1, 30);
                repeat (len) scroll_view(REQ_SCROLL_DOWN);
            end else if (kind < 82) begin
                len = $urandom_range(1, 8);
                repeat (len) scroll_view(REQ_SCROLL_UP);
            end else begin
                place_cursor(pick_position());
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Drain every outstanding result, then give the engine time to show any stray beat.
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);

        $display("Sent %0d requests: %0d prints, %0d view scrolls, %0d cursor placements.",
                 n_sent, n_print, n_scroll, n_set);
        $display("Checked %0d result beats, %0d of them with a row shift of the store.",
                 results_checked, rows_shifted);
        if (mismatch_total == 0 && pending == 0) begin
            $display("text_console_cursor_scrollback: match");
        end else begin
            $display("text_console_cursor_scrollback: mismatch");
        end
        $finish;
    end

endmodule
